### sv/mmps_pkg.sv
package mmps_pkg;

  // Field widths
  localparam int COORD_W   = 16;
  localparam int SPAN_W    = 10;
  localparam int CFG_IDX_W = 2;

  // Default buffer depth
  localparam int MAX_POINTS_DEF = 64;

  // Register reset values
  localparam logic [SPAN_W-1:0] PLOT_WIDTH_RST  = 10'd150;
  localparam logic [SPAN_W-1:0] PLOT_HEIGHT_RST = 10'd48;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PLOT_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLOT_HEIGHT = 2'd1;

  // Sequencer states
  typedef enum logic [1:0] {
    S_LOAD,
    S_FETCH,
    S_START,
    S_DIV
  } state_t;

  // One scaling job: floor(off * span / range)
  typedef struct packed {
    logic [COORD_W-1:0] off;
    logic [COORD_W-1:0] range;
    logic [SPAN_W-1:0]  span;
  } scale_job_t;

endpackage

### sv/mmps_point_if.sv
interface mmps_point_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mmps_pkg::COORD_W-1:0]  point_x;
  logic signed [mmps_pkg::COORD_W-1:0]  point_y;
  logic                                 final_point;

  modport source (output valid, output point_x, output point_y, output final_point,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input final_point,
                output ready);
endinterface

### sv/mmps_result_if.sv
interface mmps_result_if;
  logic                          valid;
  logic                          ready;
  logic [mmps_pkg::SPAN_W-1:0]   column;
  logic [mmps_pkg::SPAN_W-1:0]   row;
  logic                          end_of_run;

  modport source (output valid, output column, output row, output end_of_run,
                  input ready);
  modport sink (input valid, input column, input row, input end_of_run,
                output ready);
endinterface

### sv/mmps_cfg_if.sv
interface mmps_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mmps_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [mmps_pkg::SPAN_W-1:0]     wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

### sv/mmps_scale.sv
// Bit-serial scaler: quo = floor(off * span / range), span consumed MSB first.
// Keeps quotient and remainder of the running product; off <= range is assumed.
module mmps_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  mmps_pkg::scale_job_t        job,
  output logic                        busy,
  output logic [mmps_pkg::SPAN_W-1:0] quo
);

  localparam int CW    = mmps_pkg::COORD_W;
  localparam int SW    = mmps_pkg::SPAN_W;
  localparam int STEPW = $clog2(SW + 1);

  logic [CW-1:0]    off_r;
  logic [CW-1:0]    range_r;
  logic [SW-1:0]    span_sh;
  logic [CW-1:0]    rem;
  logic [SW-1:0]    q;
  logic             zero_rng;
  logic [STEPW-1:0] steps;

  logic [CW:0]   r2;
  logic          r2_ge;
  logic [CW:0]   r2s;
  logic [CW:0]   t;
  logic          t_ge;
  logic [CW:0]   t_sub;
  logic [SW-1:0] q2;
  logic [SW-1:0] q_next;
  logic [CW-1:0] rem_next;

  // One step: double, reduce, add off if span bit set, reduce again
  always_comb begin
    r2     = {rem, 1'b0};
    r2_ge  = (r2 >= {1'b0, range_r});
    r2s    = r2_ge ? (r2 - {1'b0, range_r}) : r2;
    q2     = {q[SW-2:0], 1'b0} + SW'(r2_ge);
    t      = span_sh[SW-1] ? (r2s + {1'b0, off_r}) : r2s;
    t_ge   = (t >= {1'b0, range_r});
    t_sub  = t_ge ? (t - {1'b0, range_r}) : t;
    rem_next = t_sub[CW-1:0];
    q_next = q2 + SW'(t_ge);
  end

  // Step counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEPW'(SW);
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (steps == STEPW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      off_r    <= job.off;
      range_r  <= job.range;
      span_sh  <= job.span;
      rem      <= '0;
      q        <= '0;
      zero_rng <= (job.range == '0);
    end else if (busy) begin
      span_sh <= {span_sh[SW-2:0], 1'b0};
      rem     <= rem_next;
      q       <= q_next;
    end
  end

  // Zero range gives offset 0
  assign quo = zero_rng ? '0 : q;

endmodule

### sv/minmax_plot_scaler_top.sv
// Min/max plot scaler. Points (point_x, point_y) are taken one per cycle while
// the block is loading; each stored point updates the running min and max of
// both coordinates, and points beyond MAX_POINTS are dropped (their final_point
// flag still counts). A point with final_point set closes the set: every
// stored point is then read back in arrival order and scaled to
// column = floor((x - xmin) * plot_width / (xmax - xmin)) and
// row = plot_rows - floor((y - ymin) * plot_rows / (ymax - ymin)), where
// plot_rows is the plot height register, a zero range giving offset 0.
// Each point is emitted through a buffer read, a setup step and the bit-serial
// scalers (one bit of the 10-bit plot span per cycle), with x and y scaled
// side by side. The next point is scaled while a result waits to be taken.
// No input is taken during emission; loading resumes once the last result
// has been registered.
module minmax_plot_scaler_top #(
  parameter int MAX_POINTS = mmps_pkg::MAX_POINTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  mmps_point_if.sink    point,
  mmps_result_if.source result,
  mmps_cfg_if.sink      cfg
);

  localparam int CW     = mmps_pkg::COORD_W;
  localparam int SW     = mmps_pkg::SPAN_W;
  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_POINTS);

  mmps_pkg::state_t state, state_next;

  logic [SW-1:0]    plot_width;
  logic [SW-1:0]    plot_rows;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic signed [CW-1:0] min_x, max_x, min_y, max_y;
  logic [2*CW-1:0]  mem [MAX_POINTS];
  logic [2*CW-1:0]  rdata;

  logic             pt_acc;
  logic             store;
  logic             start;
  logic             res_load;
  logic             idx_clr;
  logic             idx_inc;
  logic             last;
  logic             busy_x, busy_y;
  logic [SW-1:0]    quo_x, quo_y;
  mmps_pkg::scale_job_t job_x, job_y;

  logic             res_valid;
  logic [SW-1:0]    res_col;
  logic [SW-1:0]    res_row;
  logic             res_eor;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plot_width <= mmps_pkg::PLOT_WIDTH_RST;
      plot_rows  <= mmps_pkg::PLOT_HEIGHT_RST;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        mmps_pkg::REG_PLOT_WIDTH:  plot_width <= cfg.wdata;
        mmps_pkg::REG_PLOT_HEIGHT: plot_rows  <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // Loading: min/max tracking and buffer write
  assign point.ready = (state == mmps_pkg::S_LOAD);
  assign pt_acc      = point.valid && point.ready;
  assign store       = pt_acc && (count != FULL);

  always_ff @(posedge clk) begin
    if (store) begin
      if (count == '0) begin
        min_x <= point.point_x;
        max_x <= point.point_x;
        min_y <= point.point_y;
        max_y <= point.point_y;
      end else begin
        if (point.point_x < min_x) min_x <= point.point_x;
        if (point.point_x > max_x) max_x <= point.point_x;
        if (point.point_y < min_y) min_y <= point.point_y;
        if (point.point_y > max_y) max_y <= point.point_y;
      end
      mem[count[ADDR_W-1:0]] <= {point.point_x, point.point_y};
    end
    rdata <= mem[idx[ADDR_W-1:0]];
  end

  assign last = (idx == count - 1'b1);

  // Point count and read index
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      if (res_load && last) begin
        count <= '0;
      end else if (store) begin
        count <= count + 1'b1;
      end
      if (idx_clr) begin
        idx <= '0;
      end else if (idx_inc) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmps_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    start      = 1'b0;
    res_load   = 1'b0;
    idx_clr    = 1'b0;
    idx_inc    = 1'b0;
    case (state)
      mmps_pkg::S_LOAD: begin
        if (pt_acc && point.final_point) begin
          idx_clr    = 1'b1;
          state_next = mmps_pkg::S_FETCH;
        end
      end
      mmps_pkg::S_FETCH: begin
        state_next = mmps_pkg::S_START;
      end
      mmps_pkg::S_START: begin
        start      = 1'b1;
        state_next = mmps_pkg::S_DIV;
      end
      mmps_pkg::S_DIV: begin
        if (!busy_x && !busy_y && (!res_valid || result.ready)) begin
          res_load = 1'b1;
          if (last) begin
            state_next = mmps_pkg::S_LOAD;
          end else begin
            idx_inc    = 1'b1;
            state_next = mmps_pkg::S_FETCH;
          end
        end
      end
      default: state_next = mmps_pkg::S_LOAD;
    endcase
  end

  // Scaling jobs from the fetched point
  always_comb begin
    job_x.off   = CW'(rdata[2*CW-1:CW] - min_x);
    job_x.range = CW'(max_x - min_x);
    job_x.span  = plot_width;
    job_y.off   = CW'(rdata[CW-1:0] - min_y);
    job_y.range = CW'(max_y - min_y);
    job_y.span  = plot_rows;
  end

  mmps_scale u_scale_x (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .job   (job_x),
    .busy  (busy_x),
    .quo   (quo_x)
  );

  mmps_scale u_scale_y (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .job   (job_y),
    .busy  (busy_y),
    .quo   (quo_y)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_col <= quo_x;
      res_row <= plot_rows - quo_y;
      res_eor <= last;
    end
  end

  assign result.valid      = res_valid;
  assign result.column     = res_col;
  assign result.row        = res_row;
  assign result.end_of_run = res_eor;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("point count above buffer depth");

  a_idx_in_set: assert property (@(posedge clk) disable iff (rst)
    (state != mmps_pkg::S_LOAD) |-> (idx < count))
    else $error("read index outside stored set");

  a_run_closes: assert property (@(posedge clk) disable iff (rst)
    (res_load && last) |=> ((state == mmps_pkg::S_LOAD) && (count == '0)))
    else $error("set not closed after last result");

  a_minmax_order: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> ((min_x <= max_x) && (min_y <= max_y)))
    else $error("min above max");

endmodule
